FILE: src/skst_pkg.sv
package skst_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 7;
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    command_t command;
    key_t     key;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [ENTRY_W-1:0]   entry_count;
    key_t                 smallest_key;
    key_t                 largest_key;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: src/skst_cell.sv
module skst_cell (
  input  logic              clk,
  input  logic              rst,
  input  skst_pkg::cell_ctrl_t ctrl,
  input  skst_pkg::key_t    key_in,
  input  skst_pkg::key_t    prev_key,
  input  logic              prev_valid,
  input  logic              prev_lt,
  input  skst_pkg::key_t    next_key,
  input  logic              next_valid,
  output skst_pkg::key_t    key,
  output logic              valid,
  output logic              lt,
  output logic              eq
);
  import skst_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= valid && (key < key_in);
      eq <= valid && (key == key_in);
    end
    if (ctrl.ins && !lt) begin
      if (prev_lt) begin
        key <= key_in;
      end else begin
        key <= prev_key;
      end
    end else if (ctrl.rem && !lt) begin
      key <= next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && !lt) begin
      valid <= prev_lt ? 1'b1 : prev_valid;
    end else if (ctrl.rem && !lt) begin
      valid <= next_valid;
    end
  end

endmodule

FILE: src/skst_last_sel.sv
module skst_last_sel (
  input  logic                          clk,
  input  skst_pkg::key_t                keys [skst_pkg::CAPACITY],
  input  logic [skst_pkg::CAPACITY-1:0] valid,
  output skst_pkg::key_t                largest
);
  import skst_pkg::*;

  logic [CAPACITY-1:0] last;
  key_t                grp_next [NGROUP];
  key_t                grp [NGROUP];

  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      last[i] = valid[i] & ~valid[i+1];
    end
    last[CAPACITY-1] = valid[CAPACITY-1];
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          if (last[g * GROUP + j]) begin
            grp_next[g] = grp_next[g] | keys[g * GROUP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
  end

  always_comb begin
    largest = '0;
    for (int g = 0; g < NGROUP; g++) begin
      largest = largest | grp[g];
    end
  end

endmodule

FILE: src/sorted_key_set_table_unit.sv
// Sorted set of up to CAPACITY distinct 32-bit keys held in a chain of cells, slot 0
// holding the smallest. Each item asks to insert or remove one key and gives one result
// with status, entry count and the smallest and largest keys (zero when empty). From
// acceptance an item goes through these steps in order: every cell compares its key
// with the broadcast key, the cells shift up or down by a slot, a registered stage
// picks the last occupied cell, and the result register is loaded once any earlier
// result has been taken. The next item is accepted only once the result is loaded, so
// items are not overlapped. After reset the table is empty.
module sorted_key_set_table_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  skst_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output skst_pkg::rsp_t  rsp
);
  import skst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_SEL,
    S_OUT
  } state_t;

  state_t     state;
  command_t   cmd;
  key_t       key_in;
  count_t     count;
  status_t    status;
  cell_ctrl_t ctrl;

  key_t                keys [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  key_t                largest;

  logic    found;
  logic    full;
  status_t status_next;

  assign found = |eq_vec;
  assign full  = valid_vec[CAPACITY-1];

  always_comb begin
    if (cmd == CMD_INSERT) begin
      if (found) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_DONE;
      end
    end else begin
      status_next = found ? ST_DONE : ST_NOT_FOUND;
    end
  end

  always_comb begin
    ctrl.cmp = (state == S_CMP);
    ctrl.ins = (state == S_UPD) && (cmd == CMD_INSERT) && (status_next == ST_DONE);
    ctrl.rem = (state == S_UPD) && (cmd == CMD_REMOVE) && (status_next == ST_DONE);
  end

  assign req_ready = (state == S_IDLE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t prev_key;
    logic prev_valid;
    logic prev_lt;
    key_t next_key;
    logic next_valid;

    if (i == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b1;
    end else begin : g_mid
      assign prev_key   = keys[i-1];
      assign prev_valid = valid_vec[i-1];
      assign prev_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key   = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_key   = keys[i+1];
      assign next_valid = valid_vec[i+1];
    end

    skst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key_in     (key_in),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .prev_lt    (prev_lt),
      .next_key   (next_key),
      .next_valid (next_valid),
      .key        (keys[i]),
      .valid      (valid_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  skst_last_sel u_last_sel (
    .clk     (clk),
    .keys    (keys),
    .valid   (valid_vec),
    .largest (largest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd    <= req.command;
            key_in <= req.key;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          status <= status_next;
          if (ctrl.ins) begin
            count <= count + 1'b1;
          end else if (ctrl.rem) begin
            count <= count - 1'b1;
          end
          state <= S_SEL;
        end
        S_SEL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp.status           <= status;
            rsp.entry_count      <= ENTRY_W'(count);
            rsp.smallest_key     <= valid_vec[0] ? keys[0] : '0;
            rsp.largest_key      <= largest;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
